/* rtl/core/nsc_pkg.sv */
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types and codes of the satellite count parser.
// ----------------------------------------------------------------------------
package nsc_pkg;

   // Operation codes of an input transaction.
   localparam logic OP_INGEST = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_MAX_BYTES    = 2'd0;
   localparam logic [1:0] CSR_FRESH_WINDOW = 2'd1;

   localparam logic [7:0]  MAX_BYTES_RESET    = 8'd82;
   localparam logic [31:0] FRESH_WINDOW_RESET = 32'd2000;

   typedef enum logic [1:0] {
      ING_NONE   = 2'd0,
      ING_REJECT = 2'd1,
      ING_ACCEPT = 2'd2
   } ingest_type;

   typedef enum logic [1:0] {
      FIX_NONE    = 2'd0,
      FIX_INVALID = 2'd1,
      FIX_STALE   = 2'd2,
      FIX_VALID   = 2'd3
   } fix_type;

   // Latched observation.
   typedef struct packed {
      logic        have_fix;
      logic [6:0]  count;
      logic [63:0] stamp;
   } obs_type;

endpackage

/* rtl/core/nsc_parser.sv */
// ----------------------------------------------------------------------------
// nsc_parser
// Byte-wise sentence parser state and the latched satellite observation.
// ----------------------------------------------------------------------------
module nsc_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   input  logic [63:0]         time_ms,
   input  logic [7:0]          max_bytes,
   output nsc_pkg::ingest_type result,
   output nsc_pkg::obs_type    obs,
   output logic [6:0]          pending_count
);
   import nsc_pkg::*;

   typedef enum logic [2:0] {
      PH_WAIT    = 3'd0,
      PH_BODY    = 3'd1,
      PH_HI      = 3'd2,
      PH_LO      = 3'd3,
      PH_END     = 3'd4,
      PH_DISCARD = 3'd5
   } phase_type;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] PRINT_LO  = 8'h20;
   localparam logic [7:0] PRINT_HI  = 8'h7E;
   localparam logic [7:0] FIELD_MAX = 8'hFF;
   localparam logic [7:0] SAT_FIELD = 8'd7;
   localparam int         KIND_LEN  = 5;

   phase_type   phase_ff, phase_in;
   logic [8:0]  byte_count_ff, byte_count_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  check_ff, check_in;
   logic [7:0]  field_ff, field_in;
   logic [7:0]  kind_ff [KIND_LEN];
   logic [7:0]  kind_in [KIND_LEN];
   logic [2:0]  kind_len_ff, kind_len_in;
   logic [6:0]  pending_ff, pending_in;
   logic [1:0]  digits_ff, digits_in;
   logic        kind_ok_ff, kind_ok_in;
   logic        bad_ff, bad_in;
   logic        seen_cr_ff, seen_cr_in;
   obs_type     obs_ff, obs_in;

   logic       hex_ok;
   logic [3:0] hex_val;
   logic       kind_good;
   logic [8:0] count_next;
   logic [3:0] digit;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (rx_byte inside {[8'h30:8'h39]}) begin
         hex_val = rx_byte[3:0];
      end else if (rx_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         hex_val = rx_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign kind_good = (kind_len_ff == 3'd5) &&
                      (kind_ff[0] inside {[8'h41:8'h5A]}) &&
                      (kind_ff[1] inside {[8'h41:8'h5A]}) &&
                      (kind_ff[2] == 8'h47) &&
                      (((kind_ff[3] == 8'h47) && (kind_ff[4] == 8'h41)) ||
                       ((kind_ff[3] == 8'h4E) && (kind_ff[4] == 8'h53)));

   assign count_next = byte_count_ff + 9'd1;
   assign digit      = rx_byte[3:0];

   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      xor_in        = xor_ff;
      check_in      = check_ff;
      field_in      = field_ff;
      kind_in       = kind_ff;
      kind_len_in   = kind_len_ff;
      pending_in    = pending_ff;
      digits_in     = digits_ff;
      kind_ok_in    = kind_ok_ff;
      bad_in        = bad_ff;
      seen_cr_in    = seen_cr_ff;
      obs_in        = obs_ff;
      result        = ING_NONE;

      if (step) begin
         if (rx_byte == CH_DOLLAR) begin
            phase_in      = PH_BODY;
            byte_count_in = 9'd1;
            xor_in        = 8'd0;
            check_in      = 8'd0;
            field_in      = 8'd0;
            for (int i = 0; i < KIND_LEN; i++) kind_in[i] = 8'd0;
            kind_len_in   = 3'd0;
            pending_in    = 7'd0;
            digits_in     = 2'd0;
            kind_ok_in    = 1'b0;
            bad_in        = 1'b0;
            seen_cr_in    = 1'b0;
         end else if (phase_ff != PH_WAIT && phase_ff != PH_DISCARD) begin
            byte_count_in = count_next;
            if (count_next > {1'b0, max_bytes}) begin
               phase_in = PH_DISCARD;
               result   = ING_REJECT;
            end else begin
               case (phase_ff)
                  PH_BODY: begin
                     if (rx_byte == CH_STAR || rx_byte == CH_COMMA) begin
                        // Closing a field: the kind field is judged here,
                        // and an empty count field marks the sentence bad.
                        if (field_ff == 8'd0) begin
                           kind_ok_in = kind_good;
                           if (!kind_good) bad_in = 1'b1;
                        end else if (field_ff == SAT_FIELD && digits_ff == 2'd0) begin
                           bad_in = 1'b1;
                        end
                     end
                     if (rx_byte == CH_STAR) begin
                        phase_in = PH_HI;
                     end else if (rx_byte < PRINT_LO || rx_byte > PRINT_HI) begin
                        phase_in = PH_DISCARD;
                        result   = ING_REJECT;
                     end else begin
                        xor_in = xor_ff ^ rx_byte;
                        if (rx_byte == CH_COMMA) begin
                           if (field_ff != FIELD_MAX) field_in = field_ff + 8'd1;
                           else bad_in = 1'b1;
                        end else if (field_ff == 8'd0) begin
                           if (kind_len_ff < 3'd5) begin
                              for (int i = 0; i < KIND_LEN; i++) begin
                                 if (3'(i) == kind_len_ff) kind_in[i] = rx_byte;
                              end
                              kind_len_in = kind_len_ff + 3'd1;
                           end else begin
                              bad_in = 1'b1;
                           end
                        end else if (field_ff == SAT_FIELD) begin
                           if (!(rx_byte inside {[8'h30:8'h39]}) || digits_ff >= 2'd2) begin
                              bad_in = 1'b1;
                           end else begin
                              pending_in = 7'({pending_ff, 3'b000}
                                              + {2'b00, pending_ff, 1'b0}
                                              + {6'd0, digit});
                              digits_in  = digits_ff + 2'd1;
                           end
                        end
                     end
                  end
                  PH_HI: begin
                     if (!hex_ok) begin
                        phase_in = PH_DISCARD;
                        result   = ING_REJECT;
                     end else begin
                        check_in = {hex_val, 4'd0};
                        phase_in = PH_LO;
                     end
                  end
                  PH_LO: begin
                     if (!hex_ok) begin
                        phase_in = PH_DISCARD;
                        result   = ING_REJECT;
                     end else begin
                        check_in = {check_ff[7:4], hex_val};
                        phase_in = PH_END;
                     end
                  end
                  PH_END: begin
                     if (rx_byte == CH_CR && !seen_cr_ff) begin
                        seen_cr_in = 1'b1;
                     end else if (rx_byte != CH_LF) begin
                        phase_in = PH_DISCARD;
                        result   = ING_REJECT;
                     end else begin
                        phase_in = PH_WAIT;
                        if (kind_ok_ff && !bad_ff && field_ff >= SAT_FIELD &&
                            digits_ff != 2'd0 && xor_ff == check_ff) begin
                           result          = ING_ACCEPT;
                           obs_in.have_fix = 1'b1;
                           obs_in.count    = pending_ff;
                           obs_in.stamp    = time_ms;
                        end else begin
                           result = ING_REJECT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         byte_count_ff <= 9'd0;
         xor_ff        <= 8'd0;
         check_ff      <= 8'd0;
         field_ff      <= 8'd0;
         for (int i = 0; i < KIND_LEN; i++) kind_ff[i] <= 8'd0;
         kind_len_ff   <= 3'd0;
         pending_ff    <= 7'd0;
         digits_ff     <= 2'd0;
         kind_ok_ff    <= 1'b0;
         bad_ff        <= 1'b0;
         seen_cr_ff    <= 1'b0;
         obs_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         xor_ff        <= xor_in;
         check_ff      <= check_in;
         field_ff      <= field_in;
         kind_ff       <= kind_in;
         kind_len_ff   <= kind_len_in;
         pending_ff    <= pending_in;
         digits_ff     <= digits_in;
         kind_ok_ff    <= kind_ok_in;
         bad_ff        <= bad_in;
         seen_cr_ff    <= seen_cr_in;
         obs_ff        <= obs_in;
      end
   end

   // The registered observation; the freshness check handles a fix that
   // lands in this very transaction on its own.
   assign obs           = obs_ff;
   assign pending_count = pending_ff;

endmodule

/* rtl/core/nsc_freshness.sv */
// ----------------------------------------------------------------------------
// nsc_freshness
// Classifies the latched observation against the current time.
// ----------------------------------------------------------------------------
module nsc_freshness (
   input  logic                obs_valid_new,
   input  logic [6:0]          new_count,
   input  nsc_pkg::obs_type    obs,
   input  logic [63:0]         now_ms,
   input  logic [31:0]         window_ms,
   output nsc_pkg::fix_type    fix_state,
   output logic [6:0]          count,
   output logic [63:0]         stamp
);
   import nsc_pkg::*;

   logic [63:0] age;

   assign age = now_ms - obs.stamp;

   always_comb begin
      fix_state = FIX_NONE;
      count     = 7'd0;
      stamp     = 64'd0;
      if (obs_valid_new) begin
         // A fix latched by this byte carries this byte's time, so its age is zero.
         stamp = now_ms;
         if (window_ms == 32'd0) begin
            fix_state = FIX_STALE;
         end else begin
            fix_state = FIX_VALID;
            count     = new_count;
         end
      end else if (obs.have_fix) begin
         if (now_ms < obs.stamp) begin
            fix_state = FIX_INVALID;
         end else if (window_ms == 32'd0 || age >= {32'd0, window_ms}) begin
            fix_state = FIX_STALE;
            stamp     = obs.stamp;
         end else begin
            fix_state = FIX_VALID;
            count     = obs.count;
            stamp     = obs.stamp;
         end
      end
   end

endmodule

/* rtl/core/nmea_satellite_count_parser.sv */
// ----------------------------------------------------------------------------
// nmea_satellite_count_parser
// GGA/GNS sentence parser that latches the satellite count of valid sentences
// and reports the freshness of the latest observation with every transaction.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  operation, rx_byte, time_ms
// rsp       out        rsp_valid/rsp_stall  ingest_result, fix_state,
//                                           satellite_count, sample_time_ms
// csr       in         csr_write_enable     csr_index, csr_write_data
//
// One transaction per cycle sustained while rsp_stall is low; a request passes
// through the input register, then the result register, before its result is
// valid and can be taken.
// The sentence parser state updates in the single cycle that moves a
// transaction from the input register into the result register.
// A stalled result holds both registers; req_stall rises only then.
// Synchronous reset returns the parser to waiting for '$' and drops the fix.
// ----------------------------------------------------------------------------
module nmea_satellite_count_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_operation,
   input  logic [7:0]          req_rx_byte,
   input  logic [63:0]         req_time_ms,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_ingest_result,
   output logic [1:0]          rsp_fix_state,
   output logic [6:0]          rsp_satellite_count,
   output logic [63:0]         rsp_sample_time_ms,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_write_data
);
   import nsc_pkg::*;

   logic        in_valid_ff;
   logic        in_op_ff;
   logic [7:0]  in_byte_ff;
   logic [63:0] in_time_ff;

   logic [7:0]  max_bytes_ff;
   logic [31:0] window_ff;

   logic        out_valid_ff;
   ingest_type  out_result_ff;
   fix_type     out_fix_ff;
   logic [6:0]  out_count_ff;
   logic [63:0] out_stamp_ff;

   logic        advance;
   ingest_type  result;
   obs_type     obs;
   logic [6:0]  pending_count;
   fix_type     fix_state;
   logic [6:0]  count;
   logic [63:0] stamp;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
         window_ff    <= FRESH_WINDOW_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_BYTES:    max_bytes_ff <= csr_write_data[7:0];
            CSR_FRESH_WINDOW: window_ff    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_op_ff   <= req_operation;
         in_byte_ff <= req_rx_byte;
         in_time_ff <= req_time_ms;
      end
   end

   nsc_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (advance && (in_op_ff == OP_INGEST)),
      .rx_byte       (in_byte_ff),
      .time_ms       (in_time_ff),
      .max_bytes     (max_bytes_ff),
      .result        (result),
      .obs           (obs),
      .pending_count (pending_count)
   );

   nsc_freshness u_freshness (
      .obs_valid_new (result == ING_ACCEPT),
      .new_count     (pending_count),
      .obs           (obs),
      .now_ms        (in_time_ff),
      .window_ms     (window_ff),
      .fix_state     (fix_state),
      .count         (count),
      .stamp         (stamp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_result_ff <= result;
         out_fix_ff    <= fix_state;
         out_count_ff  <= count;
         out_stamp_ff  <= stamp;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_ingest_result   = out_result_ff;
   assign rsp_fix_state       = out_fix_ff;
   assign rsp_satellite_count = out_count_ff;
   assign rsp_sample_time_ms  = out_stamp_ff;

   // An accepted sentence always leaves a fresh or stale observation behind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ingest_result == ING_ACCEPT |->
         (rsp_fix_state == FIX_VALID || rsp_fix_state == FIX_STALE))
      else $error("accepted sentence without an observation");

   // Only a valid observation reports satellites.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fix_state != FIX_VALID |-> rsp_satellite_count == 7'd0)
      else $error("satellite count reported without a valid fix");

   // Input backpressure only comes from a full, stalled result register.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while the result register can move");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GGA/GNS satellite count parser. A short directed
// script is followed by randomly built sentences with injected flaws, status
// queries and time jumps across several register settings. Every result
// transaction is compared field by field against a cycle-free model of the
// parser that is kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
   import nsc_pkg::*;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] PRINT_LO  = 8'h20;
   localparam logic [7:0] PRINT_HI  = 8'h7E;
   localparam logic [7:0] FIELD_FULL = 8'hFF;
   localparam int SAT_FIELD = 7;
   localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int QUIET_LIMIT = 1000;
   localparam int NUM_PHASES = 6;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_BODY, SCAN_SUM_HI, SCAN_SUM_LO, SCAN_EOL, SCAN_SKIP
   } scan_phase_type;

   typedef struct packed {
      ingest_type  ing;
      fix_type     fix;
      logic [6:0]  sats;
      logic [63:0] stamp;
   } fix_report_type;

   typedef struct packed {
      logic        op;
      logic [7:0]  data;
      logic [63:0] stamp;
      logic        typed;
      ingest_type  ing;
      fix_type     fix;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_operation;
   logic [7:0]  req_rx_byte;
   logic [63:0] req_time_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_ingest_result;
   logic [1:0]  rsp_fix_state;
   logic [6:0]  rsp_satellite_count;
   logic [63:0] rsp_sample_time_ms;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [31:0] csr_write_data;

   nmea_satellite_count_parser uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser model state.
   scan_phase_type scan_phase;
   int          line_len;
   logic [7:0]  line_xor;
   logic [7:0]  sent_sum;
   logic [7:0]  field_idx;
   logic [7:0]  talker [5];
   int          talker_len;
   logic [6:0]  sats_acc;
   int          sats_digits;
   bit          type_good;
   bit          line_flawed;
   bit          cr_seen;
   bit          fix_held;
   logic [6:0]  held_sats;
   logic [63:0] held_stamp;
   logic [7:0]  lim_bytes;
   logic [31:0] window_ms;

   fix_report_type reports_due [$];
   fix_report_type want;
   logic [7:0]  line_bytes [$];
   script_row_type script [$];
   int          error_count = 0;
   int          quiet_cycles = 0;
   bit          calm = 1'b0;
   logic [63:0] now_ms;

   function automatic void note_error(string msg);
      error_count++;
      if (error_count <= 10) $display("%0t: %s", $time, msg);
   endfunction

   function automatic void open_sentence();
      scan_phase = SCAN_BODY;
      line_len = 1;
      line_xor = 8'h00;
      sent_sum = 8'h00;
      field_idx = 8'h00;
      foreach (talker[i]) talker[i] = 8'h00;
      talker_len = 0;
      sats_acc = 7'd0;
      sats_digits = 0;
      type_good = 1'b0;
      line_flawed = 1'b0;
      cr_seen = 1'b0;
   endfunction

   function automatic void model_reset();
      lim_bytes = MAX_BYTES_RESET;
      window_ms = FRESH_WINDOW_RESET;
      open_sentence();
      scan_phase = SCAN_IDLE;
      line_len = 0;
      fix_held = 1'b0;
      held_sats = 7'd0;
      held_stamp = 64'd0;
   endfunction

   function automatic int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
   endfunction

   function automatic bit kind_good();
      if (talker_len != 5) return 1'b0;
      if (talker[0] < "A" || talker[0] > "Z" || talker[1] < "A" || talker[1] > "Z")
         return 1'b0;
      if (talker[2] != "G") return 1'b0;
      return (talker[3] == "G" && talker[4] == "A") || (talker[3] == "N" && talker[4] == "S");
   endfunction

   function automatic void close_field();
      if (field_idx == 8'd0) begin
         type_good = kind_good();
         if (!type_good) line_flawed = 1'b1;
      end else if (field_idx == SAT_FIELD && sats_digits == 0) begin
         line_flawed = 1'b1;
      end
   endfunction

   function automatic void take_body(logic [7:0] c);
      if (c == CH_COMMA) begin
         close_field();
         if (field_idx != FIELD_FULL) field_idx++;
         else line_flawed = 1'b1;
      end else if (field_idx == 8'd0) begin
         if (talker_len < 5) begin
            talker[talker_len] = c;
            talker_len++;
         end else begin
            line_flawed = 1'b1;
         end
      end else if (field_idx == SAT_FIELD) begin
         if (c < CH_ZERO || c > CH_NINE || sats_digits >= 2) begin
            line_flawed = 1'b1;
         end else begin
            sats_acc = 7'((sats_acc * 10 + (c - CH_ZERO)) & 7'h7F);
            sats_digits++;
         end
      end
   endfunction

   function automatic ingest_type scan_byte(logic [7:0] c, logic [63:0] t);
      ingest_type res;
      int nib;
      res = ING_NONE;
      if (c == CH_DOLLAR) begin
         open_sentence();
      end else if (scan_phase != SCAN_IDLE && scan_phase != SCAN_SKIP) begin
         line_len++;
         if (line_len > lim_bytes) begin
            res = ING_REJECT;
         end else begin
            case (scan_phase)
               SCAN_BODY: begin
                  if (c == CH_STAR) begin
                     close_field();
                     scan_phase = SCAN_SUM_HI;
                  end else if (c < PRINT_LO || c > PRINT_HI) begin
                     res = ING_REJECT;
                  end else begin
                     line_xor ^= c;
                     take_body(c);
                  end
               end
               SCAN_SUM_HI, SCAN_SUM_LO: begin
                  nib = hex_val(c);
                  if (nib < 0) begin
                     res = ING_REJECT;
                  end else if (scan_phase == SCAN_SUM_HI) begin
                     sent_sum = {nib[3:0], 4'h0};
                     scan_phase = SCAN_SUM_LO;
                  end else begin
                     sent_sum[3:0] = nib[3:0];
                     scan_phase = SCAN_EOL;
                  end
               end
               default: begin
                  if (c == CH_CR && !cr_seen) begin
                     cr_seen = 1'b1;
                  end else if (c != CH_LF) begin
                     res = ING_REJECT;
                  end else begin
                     scan_phase = SCAN_IDLE;
                     if (type_good && !line_flawed && field_idx >= SAT_FIELD &&
                         sats_digits != 0 && line_xor == sent_sum) begin
                        fix_held = 1'b1;
                        held_sats = sats_acc;
                        held_stamp = t;
                        res = ING_ACCEPT;
                     end else begin
                        res = ING_REJECT;
                     end
                  end
               end
            endcase
         end
         // A reject anywhere but at the line feed drops the rest until '$'.
         if (res == ING_REJECT && scan_phase != SCAN_IDLE) scan_phase = SCAN_SKIP;
      end
      return res;
   endfunction

   function automatic fix_report_type predict_report(logic op, logic [7:0] c,
                                                     logic [63:0] t);
      fix_report_type r;
      r = '0;
      r.ing = ING_NONE;
      r.fix = FIX_NONE;
      if (op == OP_INGEST) r.ing = scan_byte(c, t);
      if (fix_held) begin
         if (t < held_stamp) begin
            r.fix = FIX_INVALID;
         end else if (window_ms == 32'd0 || t - held_stamp >= {32'd0, window_ms}) begin
            r.fix = FIX_STALE;
            r.stamp = held_stamp;
         end else begin
            r.fix = FIX_VALID;
            r.sats = held_sats;
            r.stamp = held_stamp;
         end
      end
      return r;
   endfunction

   // Called at a falling edge; returns at a falling edge.
   task automatic send_item(logic op, logic [7:0] c, logic [63:0] t, bit typed,
                            fix_report_type typed_rep);
      fix_report_type rep;
      req_valid <= 1'b1;
      req_operation <= op;
      req_rx_byte <= c;
      req_time_ms <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rep = predict_report(op, c, t);
      reports_due.push_back(typed ? typed_rep : rep);
      @(negedge clock);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   task automatic send_query();
      logic [63:0] t;
      case ($urandom_range(0, 5))
         0: t = now_ms;
         1: t = held_stamp + window_ms - 64'd1;
         2: t = held_stamp + window_ms;
         3: t = held_stamp - 64'd1;
         4: t = {$urandom, $urandom};
         default: t = now_ms + $urandom_range(0, 3000);
      endcase
      send_item(OP_QUERY, 8'($urandom), t, 1'b0, '0);
   endtask

   function automatic logic [7:0] field_char(bit wide);
      string common_set;
      logic [7:0] c;
      common_set = "0123456789.NSEWM-";
      if (!wide) return common_set[$urandom_range(0, common_set.len() - 1)];
      do c = 8'($urandom_range(PRINT_LO, PRINT_HI));
      while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA);
      return c;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return CH_ZERO + nib;
      return ($urandom_range(0, 1) ? "a" : "A") + nib - 8'd10;
   endfunction

   // Builds one sentence into line_bytes, most of them clean, the rest with one flaw.
   task automatic build_line();
      int flaw, nfields, len, f, pos;
      logic [7:0] sum;
      logic [7:0] bad;
      string bad_hex;
      string bad_sat;
      bad_hex = "/:@G`gz ";
      bad_sat = "/:A. ";
      line_bytes.delete();
      flaw = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 13) : 0;
      line_bytes.push_back(CH_DOLLAR);
      line_bytes.push_back(8'($urandom_range("A", "Z")));
      line_bytes.push_back(8'($urandom_range("A", "Z")));
      line_bytes.push_back("G");
      if ($urandom_range(0, 1)) begin
         line_bytes.push_back("G");
         line_bytes.push_back("A");
      end else begin
         line_bytes.push_back("N");
         line_bytes.push_back("S");
      end
      if (flaw == 1) line_bytes[$urandom_range(1, 5)] = field_char(1'b1);
      if (flaw == 2) line_bytes.push_back(field_char(1'b1));
      if (flaw == 3) void'(line_bytes.pop_back());
      nfields = (flaw == 4) ? $urandom_range(0, 6) : $urandom_range(7, 14);
      for (f = 1; f <= nfields; f++) begin
         line_bytes.push_back(CH_COMMA);
         if (f == SAT_FIELD) begin
            case (flaw)
               5: ;
               6: repeat (3) line_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
               7: begin
                  if ($urandom_range(0, 1))
                     line_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                  line_bytes.push_back(bad_sat[$urandom_range(0, bad_sat.len() - 1)]);
               end
               default:
                  repeat ($urandom_range(1, 2))
                     line_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            endcase
         end else begin
            len = (flaw == 13 && f == 1) ? $urandom_range(40, 250) : $urandom_range(0, 6);
            repeat (len) line_bytes.push_back(field_char($urandom_range(0, 9) == 0));
         end
      end
      if (flaw == 8) begin
         bad = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h1F))
                                    : 8'($urandom_range(8'h7F, 8'hFF));
         pos = $urandom_range(1, line_bytes.size() - 1);
         line_bytes.insert(pos, bad);
      end
      sum = 8'h00;
      for (f = 1; f < line_bytes.size(); f++) sum ^= line_bytes[f];
      if (flaw == 9) sum ^= 8'($urandom_range(1, 255));
      line_bytes.push_back(CH_STAR);
      line_bytes.push_back(hex_char(sum[7:4]));
      line_bytes.push_back(hex_char(sum[3:0]));
      if (flaw == 10)
         line_bytes[line_bytes.size() - 1 - $urandom_range(0, 1)] =
            bad_hex[$urandom_range(0, bad_hex.len() - 1)];
      if (flaw == 11) begin
         line_bytes.push_back(CH_CR);
         line_bytes.push_back($urandom_range(0, 1) ? CH_CR : field_char(1'b1));
      end else if ($urandom_range(0, 1)) begin
         line_bytes.push_back(CH_CR);
      end
      line_bytes.push_back(CH_LF);
      // A cut sentence is left unfinished; the next '$' restarts the parser.
      if (flaw == 12) begin
         len = $urandom_range(1, line_bytes.size() - 1);
         while (line_bytes.size() > len) void'(line_bytes.pop_back());
      end
   endtask

   task automatic apply_settings(logic [7:0] mx, logic [31:0] win);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_MAX_BYTES;
      csr_write_data <= {24'd0, mx};
      @(negedge clock);
      csr_index <= CSR_FRESH_WINDOW;
      csr_write_data <= win;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      lim_bytes = mx;
      window_ms = win;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (reports_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(0, 20)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reports_due.size() == 0) begin
            note_error("result transaction with no request outstanding");
         end else begin
            want = reports_due.pop_front();
            if (rsp_ingest_result !== want.ing || rsp_fix_state !== want.fix ||
                rsp_satellite_count !== want.sats || rsp_sample_time_ms !== want.stamp)
               note_error($sformatf({"mismatch: expected ingest %0d fix %0d count %0d ",
                  "stamp %0h, got ingest %0d fix %0d count %0d stamp %0h"},
                  want.ing, want.fix, want.sats, want.stamp, rsp_ingest_result,
                  rsp_fix_state, rsp_satellite_count, rsp_sample_time_ms));
         end
      end
   end

   // Ends a hung run: counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      string good_line;
      fix_report_type typed_rep;
      script_row_type row;
      logic [7:0] mx;
      logic [31:0] win;
      int ph, budget, sent;

      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_INGEST;
      req_rx_byte = 8'h00;
      req_time_ms = 64'd0;
      csr_write_enable = 1'b0;
      csr_index = CSR_MAX_BYTES;
      csr_write_data = 32'd0;
      model_reset();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed script: idle handling, early rejects, then one sentence that should
      // latch, and a query stamped before it.
      script = '{
         '{OP_QUERY,  8'h00,     64'd0, 1'b1, ING_NONE,   FIX_NONE},
         '{OP_INGEST, 8'hFF,     T_MAX, 1'b1, ING_NONE,   FIX_NONE},
         '{OP_INGEST, CH_DOLLAR, 64'd1, 1'b1, ING_NONE,   FIX_NONE},
         '{OP_INGEST, 8'h7F,     64'd2, 1'b1, ING_REJECT, FIX_NONE},
         '{OP_INGEST, CH_DOLLAR, 64'd3, 1'b1, ING_NONE,   FIX_NONE},
         '{OP_INGEST, CH_STAR,   64'd4, 1'b1, ING_NONE,   FIX_NONE},
         '{OP_INGEST, "g",       64'd5, 1'b1, ING_REJECT, FIX_NONE}
      };
      good_line = "$GNGNS,,,,,,,9*46\n";
      for (int i = 0; i < good_line.len(); i++)
         script.push_back(script_row_type'{OP_INGEST, good_line[i], 64'd1000 + i, 1'b0,
                                           ING_NONE, FIX_NONE});
      script.push_back(script_row_type'{OP_QUERY, 8'h5A, 64'd999, 1'b0, ING_NONE,
                                        FIX_NONE});

      foreach (script[i]) begin
         row = script[i];
         typed_rep = '0;
         typed_rep.ing = row.ing;
         typed_rep.fix = row.fix;
         send_item(row.op, row.data, row.stamp, row.typed, typed_rep);
      end

      now_ms = 64'd2000;
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph != 0) begin
            drain();
            case (ph)
               1: begin mx = 8'd255; win = 32'hFFFF_FFFF; end
               2: begin mx = 8'd1; win = 32'd0; end
               3: begin mx = 8'($urandom_range(20, 60)); win = $urandom_range(1, 500); end
               4: begin mx = MAX_BYTES_RESET; win = 32'd1; end
               default: begin mx = 8'($urandom_range(60, 255)); win = $urandom; end
            endcase
            apply_settings(mx, win);
         end
         calm = (ph == NUM_PHASES - 1);
         budget = (ph == 2) ? 60 : 200;
         sent = 0;
         while (sent < budget) begin
            case ($urandom_range(0, 19))
               0, 1: now_ms += $urandom_range(1000, 5000);
               2: now_ms -= $urandom_range(0, 500);
               3: now_ms = {$urandom, $urandom};
               4: now_ms = T_MAX - $urandom_range(0, 200);
               default: now_ms += $urandom_range(0, 50);
            endcase
            if ($urandom_range(0, 5) == 0)
               repeat ($urandom_range(1, 4))
                  send_item(OP_INGEST, 8'($urandom), now_ms, 1'b0, '0);
            build_line();
            foreach (line_bytes[i]) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_query();
                  sent++;
               end
               now_ms += $urandom_range(0, 3);
               send_item(OP_INGEST, line_bytes[i], now_ms, 1'b0, '0);
               sent++;
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0 && reports_due.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

/* nmea_satellite_count_parser.f */
rtl/core/nsc_pkg.sv
rtl/core/nsc_parser.sv
rtl/core/nsc_freshness.sv
rtl/core/nmea_satellite_count_parser.sv
tb/tb_top.sv
